// ===== design/polyline_densify_unit_macros.svh =====
// Assertion macros shared by the checker of the polyline densify unit.
`ifndef POLYLINE_DENSIFY_UNIT_MACROS_SVH
`define POLYLINE_DENSIFY_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define PDU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define PDU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pdu_pkg.sv =====
// Package with widths, codes and controller/datapath signal groups of the densify unit.
package pdu_pkg;

   localparam int unsigned COORD_W    = 32;
   localparam int unsigned SPACE_W    = 31;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned MAX_INSERT = 32;

   localparam logic [SPACE_W-1:0] SPACING_RESET = SPACE_W'(256);

   localparam int unsigned DIFF_W  = COORD_W + 1;
   localparam int unsigned MAG_W   = COORD_W;
   localparam int unsigned PROD_W  = 2 * MAG_W;
   localparam int unsigned RAD_W   = 2 * MAG_W + 1;
   localparam int unsigned ROOT_W  = (RAD_W + 1) / 2 + FRAC_W;
   localparam int unsigned SQSRC_W = 2 * ROOT_W;
   localparam int unsigned REM_W   = ROOT_W + 3;
   localparam int unsigned NUM_W   = SPACE_W + MAG_W;
   localparam int unsigned DIV_W   = NUM_W + 2 * FRAC_W + 1;
   localparam int unsigned QUO_W   = ROOT_W + 1;
   localparam int unsigned STEP_W  = QUO_W;
   localparam int unsigned ACC_W   = COORD_W + FRAC_W + 7;
   localparam int unsigned RND_W   = ACC_W - FRAC_W;
   localparam int unsigned CNT_W   = $clog2(DIV_W + 1);
   localparam int unsigned N_W     = $clog2(MAX_INSERT + 1);

   typedef enum logic [1:0] {
      MUL_AX_AX,
      MUL_AY_AY,
      MUL_S_AX,
      MUL_S_AY
   } pdu_mul_sel_type;

   typedef enum logic {
      DIV_SRC_COUNT,
      DIV_SRC_STEP
   } pdu_div_src_type;

   typedef enum logic [1:0] {
      OUT_PREV,
      OUT_POINT,
      OUT_CUR
   } pdu_out_sel_type;

   typedef struct packed {
      logic            load_in;
      logic            diff;
      logic            n_clear;
      logic            mul_en;
      pdu_mul_sel_type mul_sel;
      logic            rad_load;
      logic            rad_add;
      logic            root_init;
      logic            root_step;
      logic            div_load;
      pdu_div_src_type div_src;
      logic            div_step;
      logic            n_save;
      logic            stepx_save;
      logic            stepy_save;
      logic            acc_init;
      logic            out_load;
      pdu_out_sel_type out_sel;
      logic            out_last;
      logic            commit;
   } pdu_cmd_type;

   typedef struct packed {
      logic           fin;
      logic           rad_zero;
      logic           out_free;
      logic [N_W-1:0] n;
   } pdu_sts_type;

endpackage

// ===== design/pdu_if.sv =====
// Channel interfaces of the densify unit: vertex requests, point responses, spacing writes.
interface pdu_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pdu_pkg::COORD_W-1:0]   px;
   logic signed [pdu_pkg::COORD_W-1:0]   py;
   logic                                 final_vertex;

   modport source (output valid, output px, output py, output final_vertex, input ready);
   modport sink   (input valid, input px, input py, input final_vertex, output ready);
endinterface

interface pdu_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pdu_pkg::COORD_W-1:0]   qx;
   logic signed [pdu_pkg::COORD_W-1:0]   qy;
   logic                                 interpolated;
   logic                                 capped;
   logic                                 end_of_run;

   modport source (output valid, output qx, output qy, output interpolated,
                   output capped, output end_of_run, input ready);
   modport sink   (input valid, input qx, input qy, input interpolated,
                   input capped, input end_of_run, output ready);
endinterface

interface pdu_csr_if;
   logic                               valid;
   logic                               ready;
   logic [pdu_pkg::SPACE_W-1:0]        spacing;

   modport source (output valid, output spacing, input ready);
   modport sink   (input valid, input spacing, output ready);
endinterface

// ===== design/pdu_dpath.sv =====
// Datapath: leg geometry, bit-serial square root and divider, point accumulators, output register.
module pdu_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  pdu_pkg::pdu_cmd_type                cmd,
   output pdu_pkg::pdu_sts_type                sts,
   input  logic signed [pdu_pkg::COORD_W-1:0]  req_px,
   input  logic signed [pdu_pkg::COORD_W-1:0]  req_py,
   input  logic                                req_final,
   input  logic                                csr_valid,
   input  logic [pdu_pkg::SPACE_W-1:0]         csr_spacing,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pdu_pkg::COORD_W-1:0]  rsp_qx,
   output logic signed [pdu_pkg::COORD_W-1:0]  rsp_qy,
   output logic                                rsp_interpolated,
   output logic                                rsp_capped,
   output logic                                rsp_end_of_run
);

   localparam int unsigned COORD_W = pdu_pkg::COORD_W;
   localparam int unsigned SPACE_W = pdu_pkg::SPACE_W;
   localparam int unsigned FRAC_W  = pdu_pkg::FRAC_W;
   localparam int unsigned DIFF_W  = pdu_pkg::DIFF_W;
   localparam int unsigned MAG_W   = pdu_pkg::MAG_W;
   localparam int unsigned PROD_W  = pdu_pkg::PROD_W;
   localparam int unsigned RAD_W   = pdu_pkg::RAD_W;
   localparam int unsigned ROOT_W  = pdu_pkg::ROOT_W;
   localparam int unsigned SQSRC_W = pdu_pkg::SQSRC_W;
   localparam int unsigned REM_W   = pdu_pkg::REM_W;
   localparam int unsigned NUM_W   = pdu_pkg::NUM_W;
   localparam int unsigned DIV_W   = pdu_pkg::DIV_W;
   localparam int unsigned QUO_W   = pdu_pkg::QUO_W;
   localparam int unsigned STEP_W  = pdu_pkg::STEP_W;
   localparam int unsigned ACC_W   = pdu_pkg::ACC_W;
   localparam int unsigned RND_W   = pdu_pkg::RND_W;
   localparam int unsigned N_W     = pdu_pkg::N_W;

   logic [SPACE_W-1:0]              spacing_ff;
   logic                            rsp_valid_ff;

   logic signed [COORD_W-1:0]       cur_x_ff, cur_y_ff, prev_x_ff, prev_y_ff;
   logic                            fin_ff;
   logic [MAG_W-1:0]                ax_ff, ay_ff;
   logic                            negx_ff, negy_ff;
   logic [PROD_W-1:0]               prod_ff;
   logic [RAD_W-1:0]                rad_ff;
   logic [SQSRC_W-1:0]              sqsrc_ff;
   logic [REM_W-1:0]                rem_ff;
   logic [ROOT_W-1:0]               root_ff;
   logic [DIV_W-1:0]                dnum_ff;
   logic [ROOT_W-1:0]               dden_ff, drem_ff;
   logic [QUO_W-1:0]                quo_ff;
   logic [N_W-1:0]                  n_ff;
   logic                            cap_ff;
   logic signed [STEP_W:0]          stepx_ff, stepy_ff;
   logic signed [ACC_W-1:0]         accx_ff, accy_ff;
   logic signed [COORD_W-1:0]       qx_ff, qy_ff;
   logic                            interp_ff, capped_ff, last_ff;

   logic [SPACE_W-1:0]              s_eff;
   logic signed [DIFF_W-1:0]        dx, dy;
   logic [MAG_W-1:0]                mul_a, mul_b;
   logic [PROD_W-1:0]               mul_p;
   logic [REM_W-1:0]                rem_sh, root_trial;
   logic [ROOT_W:0]                 div_r2;
   logic [QUO_W:0]                  quo_rnd;
   logic [STEP_W:0]                 step_mag;
   logic signed [ACC_W-1:0]         accx_in, accy_in;
   logic                            out_free;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [RND_W-1:0] v);
      logic all_one, all_zero;
      all_one  = &v[RND_W-1:COORD_W-1];
      all_zero = ~|v[RND_W-1:COORD_W-1];
      if (all_one || all_zero) begin
         sat_coord = v[COORD_W-1:0];
      end else if (v[RND_W-1]) begin
         sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   assign s_eff = (spacing_ff == '0) ? SPACE_W'(1) : spacing_ff;
   assign dx    = DIFF_W'(cur_x_ff) - DIFF_W'(prev_x_ff);
   assign dy    = DIFF_W'(cur_y_ff) - DIFF_W'(prev_y_ff);

   always_comb begin
      case (cmd.mul_sel)
         pdu_pkg::MUL_AX_AX: begin mul_a = ax_ff;              mul_b = ax_ff; end
         pdu_pkg::MUL_AY_AY: begin mul_a = ay_ff;              mul_b = ay_ff; end
         pdu_pkg::MUL_S_AX:  begin mul_a = MAG_W'(s_eff);      mul_b = ax_ff; end
         default:            begin mul_a = MAG_W'(s_eff);      mul_b = ay_ff; end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Restoring square root: bring down one bit pair, try 4*root+1.
   assign rem_sh     = {rem_ff[REM_W-3:0], sqsrc_ff[SQSRC_W-1 -: 2]};
   assign root_trial = {{(REM_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};

   // Restoring division: bring down one dividend bit.
   assign div_r2 = {drem_ff, dnum_ff[DIV_W-1]};

   assign quo_rnd  = (QUO_W+1)'(quo_ff) + (QUO_W+1)'(1);
   assign step_mag = {1'b0, quo_rnd[QUO_W:1]};

   assign accx_in  = accx_ff + ACC_W'(stepx_ff);
   assign accy_in  = accy_ff + ACC_W'(stepy_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff   <= pdu_pkg::SPACING_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            spacing_ff <= csr_spacing;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         cur_x_ff <= req_px;
         cur_y_ff <= req_py;
         fin_ff   <= req_final;
      end
      if (cmd.commit) begin
         prev_x_ff <= cur_x_ff;
         prev_y_ff <= cur_y_ff;
      end
      if (cmd.diff) begin
         negx_ff <= dx[DIFF_W-1];
         negy_ff <= dy[DIFF_W-1];
         ax_ff   <= dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
         ay_ff   <= dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.rad_load) begin
         rad_ff <= RAD_W'(prod_ff);
      end else if (cmd.rad_add) begin
         rad_ff <= rad_ff + RAD_W'(prod_ff);
      end
      if (cmd.root_init) begin
         sqsrc_ff <= {{(SQSRC_W-RAD_W-2*FRAC_W){1'b0}}, rad_ff, {(2*FRAC_W){1'b0}}};
         rem_ff   <= '0;
         root_ff  <= '0;
      end else if (cmd.root_step) begin
         sqsrc_ff <= {sqsrc_ff[SQSRC_W-3:0], 2'b00};
         if (rem_sh >= root_trial) begin
            rem_ff  <= rem_sh - root_trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.div_load) begin
         drem_ff <= '0;
         quo_ff  <= '0;
         if (cmd.div_src == pdu_pkg::DIV_SRC_COUNT) begin
            dnum_ff <= {root_ff, {(DIV_W-ROOT_W){1'b0}}};
            dden_ff <= {{(ROOT_W-SPACE_W-FRAC_W){1'b0}}, s_eff, {FRAC_W{1'b0}}};
         end else begin
            dnum_ff <= {prod_ff[NUM_W-1:0], {(DIV_W-NUM_W){1'b0}}};
            dden_ff <= root_ff;
         end
      end else if (cmd.div_step) begin
         dnum_ff <= {dnum_ff[DIV_W-2:0], 1'b0};
         if (div_r2 >= {1'b0, dden_ff}) begin
            drem_ff <= ROOT_W'(div_r2 - {1'b0, dden_ff});
            quo_ff  <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            drem_ff <= div_r2[ROOT_W-1:0];
            quo_ff  <= {quo_ff[QUO_W-2:0], 1'b0};
         end
      end
      if (cmd.n_clear) begin
         n_ff   <= '0;
         cap_ff <= 1'b0;
      end else if (cmd.n_save) begin
         if (quo_ff > QUO_W'(pdu_pkg::MAX_INSERT)) begin
            n_ff   <= N_W'(pdu_pkg::MAX_INSERT);
            cap_ff <= 1'b1;
         end else begin
            n_ff   <= quo_ff[N_W-1:0];
            cap_ff <= 1'b0;
         end
      end
      if (cmd.stepx_save) begin
         stepx_ff <= negx_ff ? -$signed(step_mag) : $signed(step_mag);
      end
      if (cmd.stepy_save) begin
         stepy_ff <= negy_ff ? -$signed(step_mag) : $signed(step_mag);
      end
      // The rounding half is folded into the start value.
      if (cmd.acc_init) begin
         accx_ff <= {{(ACC_W-COORD_W-FRAC_W){prev_x_ff[COORD_W-1]}}, prev_x_ff,
                     1'b1, {(FRAC_W-1){1'b0}}};
         accy_ff <= {{(ACC_W-COORD_W-FRAC_W){prev_y_ff[COORD_W-1]}}, prev_y_ff,
                     1'b1, {(FRAC_W-1){1'b0}}};
      end else if (cmd.out_load && cmd.out_sel == pdu_pkg::OUT_POINT) begin
         accx_ff <= accx_in;
         accy_ff <= accy_in;
      end
      if (cmd.out_load) begin
         last_ff <= cmd.out_last;
         case (cmd.out_sel)
            pdu_pkg::OUT_PREV: begin
               qx_ff <= prev_x_ff; qy_ff <= prev_y_ff;
               interp_ff <= 1'b0;  capped_ff <= cap_ff;
            end
            pdu_pkg::OUT_POINT: begin
               qx_ff <= sat_coord(accx_in[ACC_W-1:FRAC_W]);
               qy_ff <= sat_coord(accy_in[ACC_W-1:FRAC_W]);
               interp_ff <= 1'b1;  capped_ff <= cap_ff;
            end
            default: begin
               qx_ff <= cur_x_ff;  qy_ff <= cur_y_ff;
               interp_ff <= 1'b0;  capped_ff <= 1'b0;
            end
         endcase
      end
   end

   assign sts.fin      = fin_ff;
   assign sts.rad_zero = (rad_ff == '0);
   assign sts.out_free = out_free;
   assign sts.n        = n_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_qx           = qx_ff;
   assign rsp_qy           = qy_ff;
   assign rsp_interpolated = interp_ff;
   assign rsp_capped       = capped_ff;
   assign rsp_end_of_run   = last_ff;

endmodule

// ===== design/pdu_ctrl.sv =====
// Controller: sequences the leg computation and the emission of points.
module pdu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output pdu_pkg::pdu_cmd_type cmd,
   input  pdu_pkg::pdu_sts_type sts
);

   localparam int unsigned CNT_W  = pdu_pkg::CNT_W;
   localparam int unsigned N_W    = pdu_pkg::N_W;

   typedef enum logic [4:0] {
      S_IDLE, S_DIFF, S_SQX, S_SQY, S_ADD, S_ROOT_INIT, S_ROOT,
      S_DIVN_INIT, S_DIVN, S_NSAVE, S_MULX, S_DIVX_INIT, S_DIVX, S_STEPX,
      S_MULY, S_DIVY_INIT, S_DIVY, S_STEPY, S_EMIT_PREV, S_EMIT_INS,
      S_EMIT_FIN, S_COMMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [N_W-1:0]   ins_ff, ins_in;
   logic             have_prev_ff, have_prev_in;
   logic             cnt_root_end, cnt_div_end;
   logic             n_zero, ins_end;

   assign cnt_root_end = (cnt_ff == CNT_W'(pdu_pkg::ROOT_W - 1));
   assign cnt_div_end  = (cnt_ff == CNT_W'(pdu_pkg::DIV_W - 1));
   assign n_zero       = (sts.n == '0);
   assign ins_end      = ((ins_ff + N_W'(1)) == sts.n);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff + CNT_W'(1);
      ins_in       = ins_ff;
      have_prev_in = have_prev_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = have_prev_ff ? S_DIFF : S_EMIT_FIN;
            end
         end
         S_DIFF: begin
            cmd.diff    = 1'b1;
            cmd.n_clear = 1'b1;
            state_in    = S_SQX;
         end
         S_SQX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pdu_pkg::MUL_AX_AX;
            state_in    = S_SQY;
         end
         S_SQY: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = pdu_pkg::MUL_AY_AY;
            cmd.rad_load = 1'b1;
            state_in     = S_ADD;
         end
         S_ADD: begin
            cmd.rad_add = 1'b1;
            state_in    = S_ROOT_INIT;
         end
         S_ROOT_INIT: begin
            cnt_in = '0;
            if (sts.rad_zero) begin
               state_in = S_EMIT_PREV;
            end else begin
               cmd.root_init = 1'b1;
               state_in      = S_ROOT;
            end
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_root_end) begin
               state_in = S_DIVN_INIT;
            end
         end
         S_DIVN_INIT: begin
            cmd.div_load = 1'b1;
            cmd.div_src  = pdu_pkg::DIV_SRC_COUNT;
            cnt_in       = '0;
            state_in     = S_DIVN;
         end
         S_DIVN: begin
            cmd.div_step = 1'b1;
            if (cnt_root_end) begin
               state_in = S_NSAVE;
            end
         end
         S_NSAVE: begin
            cmd.n_save = 1'b1;
            state_in   = S_MULX;
         end
         S_MULX: begin
            if (n_zero) begin
               state_in = S_EMIT_PREV;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = pdu_pkg::MUL_S_AX;
               state_in    = S_DIVX_INIT;
            end
         end
         S_DIVX_INIT: begin
            cmd.div_load = 1'b1;
            cmd.div_src  = pdu_pkg::DIV_SRC_STEP;
            cnt_in       = '0;
            state_in     = S_DIVX;
         end
         S_DIVX: begin
            cmd.div_step = 1'b1;
            if (cnt_div_end) begin
               state_in = S_STEPX;
            end
         end
         S_STEPX: begin
            cmd.stepx_save = 1'b1;
            state_in       = S_MULY;
         end
         S_MULY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pdu_pkg::MUL_S_AY;
            state_in    = S_DIVY_INIT;
         end
         S_DIVY_INIT: begin
            cmd.div_load = 1'b1;
            cmd.div_src  = pdu_pkg::DIV_SRC_STEP;
            cnt_in       = '0;
            state_in     = S_DIVY;
         end
         S_DIVY: begin
            cmd.div_step = 1'b1;
            if (cnt_div_end) begin
               state_in = S_STEPY;
            end
         end
         S_STEPY: begin
            cmd.stepy_save = 1'b1;
            cmd.acc_init   = 1'b1;
            state_in       = S_EMIT_PREV;
         end
         S_EMIT_PREV: begin
            ins_in = '0;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = pdu_pkg::OUT_PREV;
               cmd.out_last = n_zero && !sts.fin;
               state_in     = n_zero ? S_EMIT_FIN : S_EMIT_INS;
            end
         end
         S_EMIT_INS: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = pdu_pkg::OUT_POINT;
               cmd.out_last = ins_end && !sts.fin;
               ins_in       = ins_ff + N_W'(1);
               if (ins_end) begin
                  state_in = S_EMIT_FIN;
               end
            end
         end
         S_EMIT_FIN: begin
            if (!sts.fin) begin
               state_in = S_COMMIT;
            end else if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = pdu_pkg::OUT_CUR;
               cmd.out_last = 1'b1;
               state_in     = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit   = 1'b1;
            have_prev_in = !sts.fin;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ins_ff       <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ins_ff       <= ins_in;
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

// ===== design/polyline_densify_unit.sv =====
// Top level of the polyline densify unit: channels, controller and datapath.
//
// The unit takes polyline vertices one beat at a time and returns the densified
// point stream. For every leg it sends the start vertex, then floor(length /
// spacing) points spaced evenly along the leg (saturated at MAX_INSERT, with
// capped raised on that leg's beats); a vertex marked final_vertex is sent as
// well and ends the polyline. end_of_run marks the last response beat caused by
// a request beat; the first vertex of a polyline that is not final yields no
// beat. The unit works on one vertex at a time: req_chan.ready is high only
// while it is idle. A vertex with a leg of nonzero length runs through the
// bit-serial square root (49 steps) and the shared bit-serial divider (49
// steps for the count, 96 for each step component); a zero-length leg skips
// both, and a vertex that opens a polyline skips the leg work altogether.
// The response register holds a beat while it waits for rsp_chan.ready; the
// controller waits with it, so every stalled cycle adds to the vertex's time.
// The spacing register (reset 256, zero treated as one) is written over
// csr_chan, which is always ready and must be written only while the unit is
// idle.
module polyline_densify_unit (
   input  logic          clock,
   input  logic          reset,
   pdu_req_if.sink       req_chan,
   pdu_rsp_if.source     rsp_chan,
   pdu_csr_if.sink       csr_chan
);

   pdu_pkg::pdu_cmd_type cmd;
   pdu_pkg::pdu_sts_type sts;

   // Spacing writes never stall.
   assign csr_chan.ready = 1'b1;

   // The controller owns request acceptance and the sequence of steps.
   pdu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath holds the vertices, the arithmetic units and the response register.
   pdu_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_px           (req_chan.px),
      .req_py           (req_chan.py),
      .req_final        (req_chan.final_vertex),
      .csr_valid        (csr_chan.valid),
      .csr_spacing      (csr_chan.spacing),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_qx           (rsp_chan.qx),
      .rsp_qy           (rsp_chan.qy),
      .rsp_interpolated (rsp_chan.interpolated),
      .rsp_capped       (rsp_chan.capped),
      .rsp_end_of_run   (rsp_chan.end_of_run)
   );

endmodule

// ===== design/pdu_checker.sv =====
// Port checker for the polyline densify unit and its bind to the top level.
`include "polyline_densify_unit_macros.svh"

module pdu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [pdu_pkg::COORD_W-1:0] rsp_qx,
   input logic signed [pdu_pkg::COORD_W-1:0] rsp_qy,
   input logic                               rsp_interpolated,
   input logic                               rsp_capped,
   input logic                               rsp_end_of_run
);

   // A stalled response beat keeps its contents.
   `PDU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_qx) && $stable(rsp_qy) && $stable(rsp_interpolated) && $stable(rsp_capped) && $stable(rsp_end_of_run), "response beat changed while stalled")

   // One vertex at a time: acceptance closes the request side.
   `PDU_ASSERT_NEXT(a_req_single, clock, reset, req_valid && req_ready, !req_ready, "request taken while a vertex is in work")

   // While a run is incomplete, no new vertex may be taken.
   `PDU_ASSERT_NOW(a_run_open, clock, reset, rsp_valid && !rsp_end_of_run, !req_ready, "request side open inside a run")

endmodule

bind polyline_densify_unit pdu_checker u_pdu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_qx           (rsp_chan.qx),
   .rsp_qy           (rsp_chan.qy),
   .rsp_interpolated (rsp_chan.interpolated),
   .rsp_capped       (rsp_chan.capped),
   .rsp_end_of_run   (rsp_chan.end_of_run)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the polyline densify unit.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One response beat as the unit should send it.
   typedef struct {
      logic signed [pdu_pkg::COORD_W-1:0] qx;
      logic signed [pdu_pkg::COORD_W-1:0] qy;
      bit                                 interpolated;
      bit                                 capped;
      bit                                 end_of_run;
   } point_type;

   // One row of the directed stimulus. When known is set, the single beat the
   // row causes is typed in the row itself instead of coming from the predictor.
   typedef struct {
      logic signed [pdu_pkg::COORD_W-1:0] px;
      logic signed [pdu_pkg::COORD_W-1:0] py;
      bit                                 fin;
      bit                                 known;
      logic signed [pdu_pkg::COORD_W-1:0] ex;
      logic signed [pdu_pkg::COORD_W-1:0] ey;
   } vertex_row_type;

   localparam logic signed [pdu_pkg::COORD_W-1:0] CMAX = 32'sh7fff_ffff;
   localparam logic signed [pdu_pkg::COORD_W-1:0] CMIN = 32'sh8000_0000;
   localparam int unsigned SETTLE = 400;   // cycles that cover one vertex's work

   bit   clock = 1'b0;
   logic reset = 1'b1;

   pdu_req_if req_if ();
   pdu_rsp_if rsp_if ();
   pdu_csr_if csr_if ();

   polyline_densify_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source),
      .csr_chan (csr_if.sink)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the unit's state and spacing register.
   logic signed [pdu_pkg::COORD_W-1:0] held_x, held_y;
   bit                                 held_valid;
   logic [pdu_pkg::SPACE_W-1:0]        spacing_shadow;

   point_type pending_points[$];
   int        error_count = 0;
   int        burst_left  = 0;
   bit        hold_request = 1'b0;

   // Rounds an accumulator with FRAC_W fraction bits to the nearest integer,
   // halves going up, and saturates to the coordinate range.
   function automatic logic signed [pdu_pkg::COORD_W-1:0] round_acc(longint signed acc);
      longint signed r;
      r = (acc + (64'sd1 <<< (pdu_pkg::FRAC_W - 1))) >>> pdu_pkg::FRAC_W;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[pdu_pkg::COORD_W-1:0];
   endfunction

   // Works out the beats that one vertex causes and advances the shadow state.
   function automatic void densify_vertex(input logic signed [pdu_pkg::COORD_W-1:0] x,
                                          input logic signed [pdu_pkg::COORD_W-1:0] y,
                                          input bit fin,
                                          ref point_type pts[$]);
      longint signed  dx, dy, stx, sty, accx, accy;
      bit [127:0]     ax, ay, rad, root, cand, lq, s, n, qx, qy;
      bit             cap;
      point_type      p;
      pts.delete();
      if (held_valid) begin
         dx  = longint'(x) - longint'(held_x);
         dy  = longint'(y) - longint'(held_y);
         ax  = (dx < 0) ? -dx : dx;
         ay  = (dy < 0) ? -dy : dy;
         rad = ax * ax + ay * ay;
         s   = (spacing_shadow == 0) ? 1 : spacing_shadow;
         n   = 0;
         cap = 1'b0;
         lq  = 0;
         if (rad != 0) begin
            // floor(sqrt(rad) * 2^FRAC_W), found bit by bit.
            root = 0;
            for (int b = 56; b >= 0; b--) begin
               cand = root | (128'd1 << b);
               if (cand * cand <= (rad << (2 * pdu_pkg::FRAC_W))) root = cand;
            end
            lq = root;
            n  = lq / (s << pdu_pkg::FRAC_W);
            if (n > pdu_pkg::MAX_INSERT) begin
               n   = pdu_pkg::MAX_INSERT;
               cap = 1'b1;
            end
         end
         p = '{held_x, held_y, 1'b0, cap, 1'b0};
         pts.insert(pts.size(), p);
         if (n > 0) begin
            qx   = ((((s * ax) << (2 * pdu_pkg::FRAC_W + 1)) / lq) + 1) >> 1;
            qy   = ((((s * ay) << (2 * pdu_pkg::FRAC_W + 1)) / lq) + 1) >> 1;
            stx  = (dx < 0) ? -longint'(qx[63:0]) : longint'(qx[63:0]);
            sty  = (dy < 0) ? -longint'(qy[63:0]) : longint'(qy[63:0]);
            accx = longint'(held_x) * (64'sd1 <<< pdu_pkg::FRAC_W);
            accy = longint'(held_y) * (64'sd1 <<< pdu_pkg::FRAC_W);
            for (int i = 0; i < int'(n); i++) begin
               accx += stx;
               accy += sty;
               p = '{round_acc(accx), round_acc(accy), 1'b1, cap, 1'b0};
               pts.insert(pts.size(), p);
            end
         end
      end
      if (fin) begin
         p = '{x, y, 1'b0, 1'b0, 1'b0};
         pts.insert(pts.size(), p);
      end
      held_valid = !fin;
      held_x     = x;
      held_y     = y;
      if (pts.size() > 0) pts[pts.size()-1].end_of_run = 1'b1;
   endfunction

   // Offers one vertex beat, in bursts with random gaps, and files its
   // expected points before the beat can be taken.
   task automatic send_vertex(input logic signed [pdu_pkg::COORD_W-1:0] x,
                              input logic signed [pdu_pkg::COORD_W-1:0] y,
                              input bit fin, input bit known,
                              input logic signed [pdu_pkg::COORD_W-1:0] ex,
                              input logic signed [pdu_pkg::COORD_W-1:0] ey);
      point_type pts[$];
      point_type typed;
      int        gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 6);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      densify_vertex(x, y, fin, pts);
      if (known) begin
         typed = '{ex, ey, 1'b0, 1'b0, 1'b1};
         pending_points.insert(pending_points.size(), typed);
      end else begin
         foreach (pts[i]) pending_points.insert(pending_points.size(), pts[i]);
      end
      req_if.valid        <= 1'b1;
      req_if.px           <= x;
      req_if.py           <= y;
      req_if.final_vertex <= fin;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
   endtask

   // Stops offering beats and waits until the unit has nothing left to do.
   task automatic drain_unit();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_spacing(input logic [pdu_pkg::SPACE_W-1:0] value);
      csr_if.valid   <= 1'b1;
      csr_if.spacing <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid   <= 1'b0;
      spacing_shadow = value;
   endtask

   // Random vertex near the held one: a leg of a few spacings, sometimes a
   // repeat of the held vertex, sometimes anywhere in the coordinate range.
   function automatic logic signed [pdu_pkg::COORD_W-1:0] near_coord(
         input logic signed [pdu_pkg::COORD_W-1:0] base, input bit anywhere);
      longint signed span, v;
      if (anywhere) return $urandom();
      span = longint'((spacing_shadow == 0) ? 1 : spacing_shadow) * 24;
      if (span > 64'sd2147483647) span = 64'sd2147483647;
      v = longint'(base) + ($urandom_range(0, 1) ? 1 : -1) *
          longint'($urandom_range(0, int'(span[31:0])));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[pdu_pkg::COORD_W-1:0];
   endfunction

   // A run of random polylines; most are well formed with a handful of legs.
   task automatic random_polylines(input int vertex_budget, input bit with_pressure);
      logic signed [pdu_pkg::COORD_W-1:0] x, y;
      int sent, legs;
      bit wild;
      sent = 0;
      while (sent < vertex_budget) begin
         legs = $urandom_range(0, 7);
         x = $urandom();
         y = $urandom();
         for (int k = 0; k <= legs; k++) begin
            if (k > 0) begin
               wild = ($urandom_range(0, 6) == 0);
               if ($urandom_range(0, 9) == 0) begin
                  // Zero-length leg.
               end else begin
                  x = near_coord(x, wild);
                  y = ($urandom_range(0, 4) == 0) ? y : near_coord(y, wild);
               end
            end
            send_vertex(x, y, k == legs, 1'b0, '0, '0);
            sent++;
            if (with_pressure && sent == vertex_budget / 3) hold_request = 1'b1;
            if (with_pressure && sent == (2 * vertex_budget) / 3) begin
               // Let every expected point come back before going on.
               req_if.valid <= 1'b0;
               burst_left = 0;
               do @(posedge clock); while (pending_points.size() != 0);
            end
         end
      end
   endtask

   // Response side: checks each beat against the oldest expected point, then
   // picks ready from one of four patterns drawn at random, with one long
   // hold-off when the sender asks for it.
   initial begin : response_side
      point_type want;
      int        mode, mode_age, hold_left;
      mode = 0;
      mode_age = 0;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_points.size() == 0) begin
               $error("unexpected point beat qx=%0d qy=%0d", rsp_if.qx, rsp_if.qy);
               error_count++;
            end else begin
               want = pending_points.pop_front();
               if (rsp_if.qx !== want.qx) begin
                  $error("qx: expected %0d, got %0d", want.qx, rsp_if.qx);
                  error_count++;
               end
               if (rsp_if.qy !== want.qy) begin
                  $error("qy: expected %0d, got %0d", want.qy, rsp_if.qy);
                  error_count++;
               end
               if (rsp_if.interpolated !== want.interpolated) begin
                  $error("interpolated: expected %0b, got %0b",
                         want.interpolated, rsp_if.interpolated);
                  error_count++;
               end
               if (rsp_if.capped !== want.capped) begin
                  $error("capped: expected %0b, got %0b", want.capped, rsp_if.capped);
                  error_count++;
               end
               if (rsp_if.end_of_run !== want.end_of_run) begin
                  $error("end_of_run: expected %0b, got %0b",
                         want.end_of_run, rsp_if.end_of_run);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 600;
            rsp_if.ready <= 1'b0;
         end else begin
            mode_age++;
            if (mode_age >= 50) begin
               mode_age = 0;
               mode = $urandom_range(0, 3);
            end
            case (mode)
               0: begin
                  rsp_if.ready <= 1'b1;
               end
               1: begin
                  rsp_if.ready <= (mode_age % 3 == 0);
               end
               2: begin
                  rsp_if.ready <= $urandom_range(0, 1);
               end
               default: begin
                  rsp_if.ready <= (mode_age % 8 != 7);
               end
            endcase
         end
      end
   end

   // Directed rows, run at the reset spacing of 256.
   vertex_row_type directed_rows[] = '{
      // Single-vertex polyline: the vertex comes back alone.
      '{32'sd5, -32'sd7, 1'b1, 1'b1, 32'sd5, -32'sd7},
      // First vertex of a polyline: held, nothing comes back.
      '{32'sd0, 32'sd0, 1'b0, 1'b0, '0, '0},
      // Zero-length leg: only the held vertex comes back.
      '{32'sd0, 32'sd0, 1'b0, 1'b1, 32'sd0, 32'sd0},
      // Leg of exactly four spacings: the last inserted point repeats the end.
      '{32'sd1024, 32'sd0, 1'b1, 1'b0, '0, '0},
      // Corner to corner: the count saturates.
      '{CMIN, CMIN, 1'b0, 1'b0, '0, '0},
      '{CMAX, CMAX, 1'b0, 1'b0, '0, '0},
      '{CMAX, CMIN, 1'b0, 1'b0, '0, '0},
      '{CMIN, CMAX, 1'b0, 1'b0, '0, '0},
      '{CMIN, CMAX, 1'b1, 1'b0, '0, '0},
      // Legs heading down and left, and a fractional step.
      '{-32'sd1000, -32'sd300, 1'b0, 1'b0, '0, '0},
      '{-32'sd3000, 32'sd500, 1'b0, 1'b0, '0, '0},
      '{-32'sd2999, 32'sd1201, 1'b0, 1'b0, '0, '0},
      '{32'sd12345, -32'sd6789, 1'b1, 1'b0, '0, '0},
      // Single vertex at the extremes.
      '{CMAX, CMIN, 1'b1, 1'b1, CMAX, CMIN},
      '{CMIN, CMAX, 1'b1, 1'b1, CMIN, CMAX}
   };

   initial begin : stimulus
      logic [pdu_pkg::SPACE_W-1:0] spacing_plan[] = '{
         pdu_pkg::SPACE_W'(1000), pdu_pkg::SPACE_W'(1), pdu_pkg::SPACE_W'(0),
         pdu_pkg::SPACE_W'(31'h7fff_ffff), pdu_pkg::SPACE_W'(37)
      };
      req_if.valid        <= 1'b0;
      req_if.px           <= '0;
      req_if.py           <= '0;
      req_if.final_vertex <= 1'b0;
      csr_if.valid        <= 1'b0;
      csr_if.spacing      <= '0;
      held_x = '0;
      held_y = '0;
      held_valid = 1'b0;
      spacing_shadow = pdu_pkg::SPACING_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_vertex(directed_rows[i].px, directed_rows[i].py, directed_rows[i].fin,
                     directed_rows[i].known, directed_rows[i].ex, directed_rows[i].ey);
      random_polylines(50, 1'b1);

      // Each further spacing gets a fresh set of polylines once the unit is idle.
      foreach (spacing_plan[i]) begin
         drain_unit();
         write_spacing(spacing_plan[i]);
         random_polylines(32, 1'b0);
      end

      drain_unit();
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Ends a run that hangs, well past the slowest correct run.
   initial begin : watchdog
      #6ms;
      $display("tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
